// File: sv/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg: shared types and constants
// Frame layout, CRC constants and the decoded result record.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int          BYTE_W      = 8;
    localparam int          HELD_N      = 4;
    localparam int          COUNT_W     = 3;
    localparam int          TEMP_W      = 12;

    localparam logic [BYTE_W-1:0]  CRC_POLY    = 8'h31;
    localparam logic [COUNT_W-1:0] LAST_INDEX  = 3'd4;
    localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 12'd400;

    typedef logic [HELD_N-1:0][BYTE_W-1:0] held_bytes_t;

    typedef struct packed {
        logic                     crc_ok;
        logic [BYTE_W-1:0]        crc_residue;
        logic [5:0]               sensor_id;
        logic                     reset_flag;
        logic signed [TEMP_W-1:0] temperature_tenths;
        logic [6:0]               humidity;
        logic                     weak_battery;
    } sfcd_result_t;

endpackage

// File: sv/sfcd_crc8.sv
// ----------------------------------------------------------------------------
// sfcd_crc8: one-byte CRC-8 update
// Shifts one byte MSB first through the register, polynomial 0x31.
// ----------------------------------------------------------------------------
module sfcd_crc8 (
    input  logic [sfcd_pkg::BYTE_W-1:0] crc_in,
    input  logic [sfcd_pkg::BYTE_W-1:0] data_in,
    output logic [sfcd_pkg::BYTE_W-1:0] crc_out
);
    import sfcd_pkg::*;

    always_comb begin
        logic [BYTE_W-1:0] r;
        logic              top;
        r = crc_in;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            top = r[BYTE_W-1];
            r   = {r[BYTE_W-2:0], data_in[b]};
            if (top) begin
                r = r ^ CRC_POLY;
            end
        end
        crc_out = r;
    end

endmodule

// File: sv/sfcd_field_decode.sv
// ----------------------------------------------------------------------------
// sfcd_field_decode: frame field extraction
// Builds the result record from the held bytes and the final residue.
// ----------------------------------------------------------------------------
module sfcd_field_decode (
    input  sfcd_pkg::held_bytes_t           held_in,
    input  logic [sfcd_pkg::BYTE_W-1:0]     residue_in,
    output sfcd_pkg::sfcd_result_t          result_out
);
    import sfcd_pkg::*;

    logic [TEMP_W-1:0] hundreds;
    logic [TEMP_W-1:0] tens;
    logic [TEMP_W-1:0] units;
    logic [TEMP_W-1:0] bcd_sum;

    // nibbles above nine keep their binary weight
    assign hundreds = TEMP_W'(held_in[1][3:0]) * TEMP_W'(100);
    assign tens     = TEMP_W'(held_in[2][7:4]) * TEMP_W'(10);
    assign units    = TEMP_W'(held_in[2][3:0]);
    assign bcd_sum  = hundreds + tens + units;

    always_comb begin
        result_out.crc_ok             = (residue_in == '0);
        result_out.crc_residue        = residue_in;
        result_out.sensor_id          = {held_in[0][3:0], held_in[1][7:6]};
        result_out.reset_flag         = held_in[1][5];
        result_out.temperature_tenths = signed'(bcd_sum - TEMP_OFFSET);
        result_out.humidity           = held_in[3][6:0];
        result_out.weak_battery       = held_in[3][7];
    end

endmodule

// File: sv/sensor_frame_crc_decoder_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_top: five-byte sensor frame decoder with CRC-8
// Path: the fifth byte passes the input register, then the result register.
// Throughput: one byte per cycle unless m_tready stalls a full result register,
// set by the combinational CRC update between them; one result per five bytes.
// Reset: aresetn low clears both valid flags, the byte count and the CRC.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] crc_residue, [13:8] sensor_id,
                                   // [14] reset_flag, [26:15] temperature_tenths,
                                   // [33:27] humidity, [34] weak_battery, rest zero
    output logic [0:0]  m_tuser    // [0] crc_ok
);
    import sfcd_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    // frame state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]  crc_reg, crc_next;
    held_bytes_t        held_reg;

    // result register
    logic         m_valid_reg, m_valid_next;
    sfcd_result_t m_data_reg;

    logic               out_free;
    logic               proc_fire;
    logic               emit;
    logic [COUNT_W-1:0] eff_count;
    logic [BYTE_W-1:0]  crc_base;
    logic [BYTE_W-1:0]  crc_upd;
    held_bytes_t        held_view;
    sfcd_result_t       result;

    // the result register can take a new value when empty or being drained
    assign out_free  = !m_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    // a start mark drops any partial frame and restarts the CRC
    assign eff_count = in_start_reg ? '0 : byte_count_reg;
    assign crc_base  = in_start_reg ? '0 : crc_reg;
    assign emit      = (eff_count == LAST_INDEX);

    sfcd_crc8 u_crc8 (
        .crc_in  (crc_base),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    // bytes 0 to 3 are all held by the time the fifth byte arrives
    assign held_view = held_reg;

    sfcd_field_decode u_decode (
        .held_in    (held_view),
        .residue_in (crc_upd),
        .result_out (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        if (proc_fire) begin
            if (emit) begin
                byte_count_next = '0;
                crc_next        = '0;
            end else begin
                byte_count_next = eff_count + COUNT_W'(1);
                crc_next        = crc_upd;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = proc_fire && emit;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            byte_count_reg <= '0;
            crc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload: capture input transaction, held bytes and result
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (proc_fire && !emit) begin
            held_reg[eff_count[1:0]] <= in_byte_reg;
        end
        if (proc_fire && emit) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.crc_ok;
    assign m_tdata  = {5'b0,
                       m_data_reg.weak_battery,
                       m_data_reg.humidity,
                       m_data_reg.temperature_tenths,
                       m_data_reg.reset_flag,
                       m_data_reg.sensor_id,
                       m_data_reg.crc_residue};

    // the count never passes the fifth byte position
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= LAST_INDEX)
        else $error("byte count out of range");

    // a processed fifth byte always presents a result next cycle
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && emit |=> m_tvalid)
        else $error("fifth byte did not produce a result");

    // crc_ok agrees with the residue it was derived from
    a_crc_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tdata[7:0] == 8'h00)))
        else $error("crc_ok disagrees with residue");

    // a non-final byte leaves the result side untouched
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(proc_fire && emit) |=> !m_tvalid)
        else $error("result appeared without a fifth byte");

endmodule
